>>> sv/region_statistics_accumulator_top_defines.svh
// ---------------------------------------------------------------------------
// Region statistics accumulator assertion macros
// Property macros used by the top level; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef REGION_STATISTICS_ACCUMULATOR_TOP_DEFINES_SVH
`define REGION_STATISTICS_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define RSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/rsa_pkg.sv
// ---------------------------------------------------------------------------
// Region statistics accumulator package
// Types, constants and command structs shared by the block's modules.
// ---------------------------------------------------------------------------
package rsa_pkg;

    localparam int REGION_COUNT_DEF = 256;
    localparam int SIDE_LEN_DEF     = 256;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam logic [1:0] ACT_ACC   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_ZMASS = 2'd3;

    localparam logic [24:0] COUNT_LIMIT = 25'd16777216;

    // Packed entry layout: count, sum, min, max, three coordinate sums,
    // three weighted sums.
    localparam int ENTRY_W = 25 + 40 + 16 + 16 + 3 * 32 + 3 * 48;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] region_label;
        logic [7:0]  x_coord;
        logic [7:0]  y_coord;
        logic [7:0]  z_coord;
        logic [15:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [24:0] voxel_count;
        logic [39:0] value_sum;
        logic [15:0] value_min;
        logic [15:0] value_max;
        logic [23:0] value_mean;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] center_z;
        logic [15:0] mass_center_x;
        logic [15:0] mass_center_y;
        logic [15:0] mass_center_z;
    } out_item_t;

    typedef struct packed {
        logic [24:0] cnt;
        logic [39:0] sum;
        logic [15:0] vmin;
        logic [15:0] vmax;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [47:0] wx;
        logic [47:0] wy;
        logic [47:0] wz;
    } entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch_in;   // capture input item, start table read
        logic acc_write;  // write accumulated entry
        logic clr_write;  // write cleared entry
        logic sweep_write;// reset sweep write
        logic div_start;  // start divider on read
        logic div_sel_next; // advance to next quotient
        logic load_out;   // load result register
    } cmd_t;

    typedef struct packed {
        logic       in_range;
        logic [1:0] action;
        logic       div_done;
        logic       div_last;
        logic       sweep_last;
    } stat_t;

endpackage

>>> sv/rsa_ram.sv
// ---------------------------------------------------------------------------
// Region statistics generic RAM
// Single port write, single port registered read.
// ---------------------------------------------------------------------------
module rsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/rsa_div.sv
// ---------------------------------------------------------------------------
// Region statistics divider
// Restoring divider, one quotient bit per cycle, computes (num << 8) / den.
// ---------------------------------------------------------------------------
module rsa_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [39:0] den,
    output logic        done,
    output logic [55:0] quot
);
    import rsa_pkg::*;

    logic [55:0] dividend_reg, dividend_next;
    logic [40:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [40:0] trial;

    always_comb
    begin
        dividend_next = dividend_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[39:0], dividend_reg[55]} - {1'b0, den};
        if (start)
        begin
            dividend_next = {num, 8'd0};
            rem_next = '0;
            cnt_next = 6'd55;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[40])
            begin
                rem_next = trial;
                dividend_next = {dividend_reg[54:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[39:0], dividend_reg[55]};
                dividend_next = {dividend_reg[54:0], 1'b0};
            end
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg <= rem_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd0);
    assign quot = dividend_next;
endmodule

>>> sv/rsa_datapath.sv
// ---------------------------------------------------------------------------
// Region statistics datapath
// Region table, accumulate update, divider sequencing and result register.
// ---------------------------------------------------------------------------
module rsa_datapath #(
    parameter int REGION_COUNT = rsa_pkg::REGION_COUNT_DEF,
    parameter int SIDE_LEN     = rsa_pkg::SIDE_LEN_DEF,
    parameter int SAMPLE_BITS  = rsa_pkg::SAMPLE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rsa_pkg::in_item_t in_item,
    input  logic [15:0]      region_base,
    input  rsa_pkg::cmd_t    cmd,
    output rsa_pkg::stat_t   stat,
    output rsa_pkg::out_item_t result
);
    import rsa_pkg::*;

    localparam int IW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam logic [7:0]  SIDE_MAX = 8'((SIDE_LEN > 256) ? 255 : SIDE_LEN - 1);

    in_item_t    item_reg;
    logic [IW-1:0] idx_reg;
    logic        range_reg;
    logic [IW-1:0] sweep_reg;
    logic [2:0]  qsel_reg;
    out_item_t   res_reg;

    logic [16:0] diff;
    logic        in_range;
    entry_t      rd_entry, upd_entry, clr_entry, wr_entry;
    logic        ram_we;
    logic [IW-1:0] ram_waddr;
    logic [7:0]  cx, cy, cz;
    logic [15:0] v;
    logic [23:0] wpx, wpy, wpz;
    logic [47:0] div_num;
    logic [39:0] div_den;
    logic        div_done;
    logic [55:0] div_q;

    assign diff = {1'b0, in_item.region_label} - {1'b0, region_base};
    assign in_range = !diff[16] && (32'(diff[15:0]) < REGION_COUNT);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            item_reg <= in_item;
            idx_reg <= IW'(diff[15:0]);
            range_reg <= in_range;
        end
    end

    rsa_ram #(.WIDTH(ENTRY_W), .DEPTH(REGION_COUNT)) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wr_entry),
        .raddr(cmd.latch_in ? IW'(diff[15:0]) : idx_reg),
        .rdata(rd_entry)
    );

    always_comb
    begin
        clr_entry = '0;
        clr_entry.vmin = SAMPLE_MASK;
        cx = (item_reg.x_coord > SIDE_MAX) ? SIDE_MAX : item_reg.x_coord;
        cy = (item_reg.y_coord > SIDE_MAX) ? SIDE_MAX : item_reg.y_coord;
        cz = (item_reg.z_coord > SIDE_MAX) ? SIDE_MAX : item_reg.z_coord;
        v = item_reg.sample_value & SAMPLE_MASK;
        // Full 24-bit products of sample and coordinate.
        wpx = {8'd0, v} * {16'd0, cx};
        wpy = {8'd0, v} * {16'd0, cy};
        wpz = {8'd0, v} * {16'd0, cz};
        upd_entry = rd_entry;
        if (rd_entry.cnt < COUNT_LIMIT)
        begin
            upd_entry.cnt = rd_entry.cnt + 25'd1;
            upd_entry.sum = rd_entry.sum + 40'(v);
            upd_entry.vmin = (v < rd_entry.vmin) ? v : rd_entry.vmin;
            upd_entry.vmax = (v > rd_entry.vmax) ? v : rd_entry.vmax;
            upd_entry.px = rd_entry.px + 32'(cx);
            upd_entry.py = rd_entry.py + 32'(cy);
            upd_entry.pz = rd_entry.pz + 32'(cz);
            upd_entry.wx = rd_entry.wx + 48'(wpx);
            upd_entry.wy = rd_entry.wy + 48'(wpy);
            upd_entry.wz = rd_entry.wz + 48'(wpz);
        end
        ram_we = cmd.acc_write || cmd.clr_write || cmd.sweep_write;
        ram_waddr = cmd.sweep_write ? sweep_reg : idx_reg;
        wr_entry = cmd.acc_write ? upd_entry : clr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep_write)
        begin
            sweep_reg <= sweep_reg + IW'(1);
        end
    end

    // Quotients in order: mean, cx, cy, cz, mx, my, mz.
    always_comb
    begin
        div_den = (qsel_reg < 3'd4) ? 40'(rd_entry.cnt) : rd_entry.sum;
        case (qsel_reg)
            3'd0:    div_num = 48'(rd_entry.sum);
            3'd1:    div_num = 48'(rd_entry.px);
            3'd2:    div_num = 48'(rd_entry.py);
            3'd3:    div_num = 48'(rd_entry.pz);
            3'd4:    div_num = rd_entry.wx;
            3'd5:    div_num = rd_entry.wy;
            default: div_num = rd_entry.wz;
        endcase
    end

    rsa_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsel_reg <= '0;
        end
        else if (cmd.latch_in)
        begin
            qsel_reg <= '0;
        end
        else if (cmd.div_sel_next)
        begin
            qsel_reg <= qsel_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            res_reg <= '0;
        end
        else if (div_done)
        begin
            case (qsel_reg)
                3'd0:    res_reg.value_mean <= div_q[23:0];
                3'd1:    res_reg.center_x <= div_q[15:0];
                3'd2:    res_reg.center_y <= div_q[15:0];
                3'd3:    res_reg.center_z <= div_q[15:0];
                3'd4:    res_reg.mass_center_x <= div_q[15:0];
                3'd5:    res_reg.mass_center_y <= div_q[15:0];
                default: res_reg.mass_center_z <= div_q[15:0];
            endcase
        end
    end

    always_comb
    begin
        result = '0;
        if (!range_reg)
        begin
            result.status = (item_reg.action == ACT_NONE) ? ST_OK : ST_RANGE;
        end
        else if (item_reg.action == ACT_READ)
        begin
            result = res_reg;
            result.voxel_count = rd_entry.cnt;
            result.value_sum = rd_entry.sum;
            result.value_min = rd_entry.vmin;
            result.value_max = rd_entry.vmax;
            if (rd_entry.cnt == 25'd0)
            begin
                result.status = ST_EMPTY;
                result.value_mean = '0;
                result.center_x = '0;
                result.center_y = '0;
                result.center_z = '0;
                result.mass_center_x = '0;
                result.mass_center_y = '0;
                result.mass_center_z = '0;
            end
            else if (rd_entry.sum == 40'd0)
            begin
                result.status = ST_ZMASS;
                result.mass_center_x = '0;
                result.mass_center_y = '0;
                result.mass_center_z = '0;
            end
            else
            begin
                result.status = ST_OK;
            end
        end
    end

    assign stat.in_range = range_reg;
    assign stat.action = item_reg.action;
    assign stat.div_done = div_done;
    assign stat.div_last = (qsel_reg == 3'd6) ||
                           ((qsel_reg == 3'd3) && (rd_entry.sum == 40'd0)) ||
                           (rd_entry.cnt == 25'd0);
    assign stat.sweep_last = (32'(sweep_reg) == REGION_COUNT - 1);
endmodule

>>> sv/rsa_ctrl.sv
// ---------------------------------------------------------------------------
// Region statistics controller
// Sequences reset sweep, item capture, table access, divisions and output.
// ---------------------------------------------------------------------------
module rsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rsa_pkg::stat_t stat,
    output rsa_pkg::cmd_t  cmd
);
    import rsa_pkg::*;

    typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_READ, S_DIVS, S_DIVW, S_OUT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        in_ready = (state_reg == S_IDLE) && !out_valid_reg;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (out_valid_reg && out_ready)
                begin
                    out_valid_next = 1'b0;
                end
                if (in_valid && in_ready)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (!stat.in_range || stat.action == ACT_NONE)
                begin
                    state_next = S_OUT;
                end
                else if (stat.action == ACT_ACC)
                begin
                    cmd.acc_write = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.action == ACT_CLEAR)
                begin
                    cmd.clr_write = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    if (stat.div_last)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.div_sel_next = 1'b1;
                        state_next = S_DIVS;
                    end
                end
            end
            S_OUT:
            begin
                cmd.load_out = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

>>> sv/region_statistics_accumulator_top.sv
// ---------------------------------------------------------------------------
// Region statistics accumulator top level
// Labeled region table with accumulate, read (with fixed point means) and
// clear requests.
// ---------------------------------------------------------------------------
//   channel | signals                          | carries
//   in      | in_valid, in_ready, in_item      | one request (accumulate/read/clear)
//   out     | out_valid, out_ready, out_item   | one result per request
//   cfg     | cfg_we, cfg_data                 | region_base register
//
// An accumulate or clear request is accepted in S_IDLE, which also starts the
// table read; S_READ writes the updated or cleared entry and S_OUT loads the
// result register. The next request can be accepted in the cycle after the
// result is taken, so the block takes no new request while one is in flight.
// A read request runs its quotients one after another through one shared
// bit-serial divider, each a start state followed by 56 quotient bits: an
// occupied region needs seven quotients, a zero-mass region four and an
// empty region one. After reset the block sweeps the table, writing reset
// values to all REGION_COUNT entries, and takes no request until done. A
// result held by a stalled out_ready blocks the next request from entering
// the table.
module region_statistics_accumulator_top #(
    parameter int REGION_COUNT = rsa_pkg::REGION_COUNT_DEF,
    parameter int SIDE_LEN     = rsa_pkg::SIDE_LEN_DEF,
    parameter int SAMPLE_BITS  = rsa_pkg::SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsa_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output rsa_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);
    import rsa_pkg::*;
`include "region_statistics_accumulator_top_defines.svh"

    logic [15:0] base_reg;
    cmd_t        cmd;
    stat_t       stat;
    out_item_t   result;
    out_item_t   out_reg;

    // The region base register, written directly by the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data;
        end
    end

    rsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsa_datapath #(
        .REGION_COUNT(REGION_COUNT),
        .SIDE_LEN    (SIDE_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .region_base(base_reg),
        .cmd        (cmd),
        .stat       (stat),
        .result     (result)
    );

    // The output register holds the result until it is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= result;
        end
    end

    assign out_item = out_reg;

    // A request is never taken while a result is still waiting.
    `RSA_ASSERT_IMPL(a_no_accept_pending, clk, rst_n, out_valid, !in_ready)
    // Only one table write kind at a time.
    `RSA_ASSERT_IMPL(a_one_write, clk, rst_n, 1'b1,
        $onehot0({cmd.acc_write, cmd.clr_write, cmd.sweep_write}))
    // Loading a result makes it visible the next cycle.
    `RSA_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid)
endmodule
